[hdl/tcw_pkg.sv]
`default_nettype none

package tcw_pkg;

   // Screen geometry
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = ROWS * COLUMNS;

   localparam int COL_W   = $clog2(COLUMNS);
   localparam int ROW_W   = $clog2(ROWS);
   localparam int CELL_W  = 11;
   localparam int FUNC_W  = 2;
   localparam int CHAR_W  = 8;
   localparam int COLOR_W = 8;
   localparam int DATA_W  = COLOR_W + CHAR_W;

   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0a;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_RAW   = 2'd0,
      FUNC_TEXT  = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_READ  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KIND_PUT,
      KIND_NEWLINE,
      KIND_CLEAR,
      KIND_READ
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [CHAR_W-1:0]   char_code;
      logic [COLOR_W-1:0]  color;
      logic [CELL_W-1:0]   cell_index;
      logic                read_ok;
   } cmd_type;

   // Linear cell address of a row and column
   function automatic logic [CELL_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      return CELL_W'(row) * CELL_W'(COLUMNS) + CELL_W'(col);
   endfunction

endpackage

`default_nettype wire

[hdl/tcw_front.sv]
`default_nettype none

module tcw_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   output logic                               full,
   input  wire logic [tcw_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [tcw_pkg::CHAR_W-1:0]    req_char_code,
   input  wire logic [tcw_pkg::COLOR_W-1:0]   req_color,
   input  wire logic [tcw_pkg::CELL_W-1:0]    req_cell_index,
   input  wire logic                          hold,
   output logic                               cmd_valid,
   output tcw_pkg::cmd_type                   cmd,
   input  wire logic                          cmd_pop
);
   import tcw_pkg::*;

   cmd_type    decoded;
   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       accept;

   // Classify the incoming transaction
   always_comb begin
      decoded.char_code  = req_char_code;
      decoded.color      = req_color;
      decoded.cell_index = req_cell_index;
      decoded.read_ok    = (req_cell_index < CELL_W'(CELLS));
      unique case (func_type'(req_func))
         FUNC_RAW:   decoded.kind = KIND_PUT;
         FUNC_TEXT:  decoded.kind = (req_char_code == NEWLINE_CHAR) ? KIND_NEWLINE : KIND_PUT;
         FUNC_CLEAR: decoded.kind = KIND_CLEAR;
         FUNC_READ:  decoded.kind = KIND_READ;
         default:    decoded.kind = KIND_PUT;
      endcase
   end

   assign full      = (count_ff == 2'd2) || hold;
   assign accept    = push && !full;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept  ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(accept) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (accept) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

`default_nettype wire

[hdl/tcw_back.sv]
`default_nettype none

module tcw_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          cmd_valid,
   input  wire tcw_pkg::cmd_type              cmd,
   output logic                               cmd_pop,
   output logic                               init_busy,
   input  wire logic                          rsp_pop,
   output logic                               rsp_valid,
   output logic [tcw_pkg::CELL_W-1:0]         rsp_cursor_pos,
   output logic [tcw_pkg::DATA_W-1:0]         rsp_read_data,
   output logic                               rsp_scrolled
);
   import tcw_pkg::*;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_READ,
      S_COPY,
      S_FILL,
      S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [CELL_W-1:0]  sweep_ff, sweep_in;
   logic [CELL_W-1:0]  dst_ff, dst_in;
   logic               wr_pend_ff, wr_pend_in;
   logic [DATA_W-1:0]  fill_ff, fill_in;
   cmd_type            cmd_ff, cmd_in;
   logic [DATA_W-1:0]  data_ff, data_in;
   logic               scrolled_ff, scrolled_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]  rsp_cursor_ff, rsp_cursor_in;
   logic [DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic               rsp_scrolled_ff, rsp_scrolled_in;

   logic [DATA_W-1:0]  cells_ff [CELLS];
   logic [DATA_W-1:0]  rdata_ff;
   logic               we, re;
   logic [CELL_W-1:0]  waddr, raddr;
   logic [DATA_W-1:0]  wdata;
   logic [CELL_W-1:0]  pos;
   logic               rsp_free;
   logic               advance_row;

   assign pos       = cell_addr(row_ff, col_ff);
   assign rsp_free  = !rsp_valid_ff || rsp_pop;
   assign init_busy = (state_ff == S_INIT);

   always_comb begin
      state_in        = state_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      sweep_in        = sweep_ff;
      dst_in          = dst_ff;
      wr_pend_in      = wr_pend_ff;
      fill_in         = fill_ff;
      cmd_in          = cmd_ff;
      data_in         = data_ff;
      scrolled_in     = scrolled_ff;
      rsp_valid_in    = rsp_pop ? 1'b0 : rsp_valid_ff;
      rsp_cursor_in   = rsp_cursor_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      we              = 1'b0;
      waddr           = sweep_ff;
      wdata           = fill_ff;
      re              = 1'b0;
      raddr           = sweep_ff;
      cmd_pop         = 1'b0;
      advance_row     = 1'b0;

      unique case (state_ff)
         S_INIT: begin
            we    = 1'b1;
            wdata = '0;
            if (sweep_ff == CELL_W'(CELLS - 1)) begin
               sweep_in = '0;
               state_in = S_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (cmd_valid && rsp_free) begin
               cmd_pop     = 1'b1;
               cmd_in      = cmd;
               data_in     = '0;
               scrolled_in = 1'b0;
               fill_in     = {cmd.color, BLANK_CHAR};
               unique case (cmd.kind)
                  KIND_PUT: begin
                     we    = 1'b1;
                     waddr = pos;
                     wdata = {cmd.color, cmd.char_code};
                     if (col_ff == COL_W'(COLUMNS - 1)) begin
                        advance_row = 1'b1;
                     end else begin
                        col_in = col_ff + 1'b1;
                     end
                     state_in = S_DONE;
                  end
                  KIND_NEWLINE: begin
                     advance_row = 1'b1;
                     state_in    = S_DONE;
                  end
                  KIND_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     sweep_in = '0;
                     state_in = S_FILL;
                  end
                  KIND_READ: begin
                     re       = cmd.read_ok;
                     raddr    = cmd.cell_index;
                     state_in = S_READ;
                  end
                  default: state_in = S_IDLE;
               endcase
               if (advance_row) begin
                  col_in = '0;
                  if (row_ff == ROW_W'(ROWS - 1)) begin
                     scrolled_in = 1'b1;
                     sweep_in    = CELL_W'(COLUMNS);
                     wr_pend_in  = 1'b0;
                     state_in    = S_COPY;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end
            end
         end
         S_READ: begin
            data_in  = cmd_ff.read_ok ? rdata_ff : '0;
            state_in = S_DONE;
         end
         S_COPY: begin
            // Read one row ahead, write the previous read back one row up
            if (wr_pend_ff) begin
               we    = 1'b1;
               waddr = dst_ff;
               wdata = rdata_ff;
            end
            if (sweep_ff != CELL_W'(CELLS)) begin
               re         = 1'b1;
               raddr      = sweep_ff;
               dst_in     = sweep_ff - CELL_W'(COLUMNS);
               wr_pend_in = 1'b1;
               sweep_in   = sweep_ff + 1'b1;
            end else begin
               wr_pend_in = 1'b0;
               sweep_in   = CELL_W'((ROWS - 1) * COLUMNS);
               state_in   = S_FILL;
            end
         end
         S_FILL: begin
            we = 1'b1;
            if (sweep_ff == CELL_W'(CELLS - 1)) begin
               state_in = S_DONE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         S_DONE: begin
            rsp_valid_in    = 1'b1;
            rsp_cursor_in   = pos;
            rsp_data_in     = data_ff;
            rsp_scrolled_in = scrolled_ff;
            state_in        = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         col_ff       <= '0;
         row_ff       <= '0;
         sweep_ff     <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         sweep_ff     <= sweep_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dst_ff          <= dst_in;
      fill_ff         <= fill_in;
      cmd_ff          <= cmd_in;
      data_ff         <= data_in;
      scrolled_ff     <= scrolled_in;
      rsp_cursor_ff   <= rsp_cursor_in;
      rsp_data_ff     <= rsp_data_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

   // Screen store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         cells_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= cells_ff[raddr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_pos = rsp_cursor_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;

endmodule

`default_nettype wire

[hdl/text_console_writer_unit.sv]
`default_nettype none

// Channel     Handshake       Payload
// request     push / full     req_func, req_char_code, req_color, req_cell_index
// response    pop / empty     rsp_cursor_pos, rsp_read_data, rsp_scrolled
//
// In the back engine a put writes the store, or a newline moves the cursor, and then the
// response register is loaded; a read adds the registered store read in between.
// A clear and a scroll sweep the store one cell a cycle, and after reset the store is
// swept to zero in the same way, with full high.
// The front queue holds two transactions, so push continues while the engine works; the
// engine starts a transaction only once the response register is free.

module text_console_writer_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   output logic                               full,
   input  wire logic [tcw_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [tcw_pkg::CHAR_W-1:0]    req_char_code,
   input  wire logic [tcw_pkg::COLOR_W-1:0]   req_color,
   input  wire logic [tcw_pkg::CELL_W-1:0]    req_cell_index,
   output logic                               empty,
   input  wire logic                          pop,
   output logic [tcw_pkg::CELL_W-1:0]         rsp_cursor_pos,
   output logic [tcw_pkg::DATA_W-1:0]         rsp_read_data,
   output logic                               rsp_scrolled
);
   import tcw_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;
   logic    init_busy;
   logic    rsp_valid;
   logic    rsp_pop;

   // Front: classify each transaction and hold it until the engine is free
   tcw_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_func       (req_func),
      .req_char_code  (req_char_code),
      .req_color      (req_color),
      .req_cell_index (req_cell_index),
      .hold           (init_busy),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop)
   );

   // Drop the response once the consumer takes it
   assign empty   = !rsp_valid;
   assign rsp_pop = pop && rsp_valid;

   // Back: cursor, screen store and response register
   tcw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop),
      .init_busy      (init_busy),
      .rsp_pop        (rsp_pop),
      .rsp_valid      (rsp_valid),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_read_data  (rsp_read_data),
      .rsp_scrolled   (rsp_scrolled)
   );

endmodule

`default_nettype wire
